>>> rtl/swt_pkg.sv
// Shared types and codes for the swing trend detector.
// Used by swt_csr, swt_history, swt_pattern and swing_trend_detector.
package swt_pkg;

   localparam int HIST_DEPTH  = 5;
   localparam int PRICE_W     = 32;
   localparam int DAY_W       = 32;
   localparam int LOOKBACK_W  = 16;
   localparam int CNT_W       = 3;
   localparam int HELD_POINTS = 5;

   localparam logic [LOOKBACK_W-1:0] LOOKBACK_RESET = 16'd20;

   // swing direction
   localparam logic [1:0] DIR_UNKNOWN = 2'd0;
   localparam logic [1:0] DIR_UP      = 2'd1;
   localparam logic [1:0] DIR_DOWN    = 2'd2;
   localparam logic [1:0] DIR_BAD     = 2'd3;

   // trend kind reported per item
   localparam logic [1:0] TREND_NONE = 2'd0;
   localparam logic [1:0] TREND_UP   = 2'd1;
   localparam logic [1:0] TREND_DOWN = 2'd2;
   localparam logic [1:0] TREND_BAD  = 2'd3;

   // pattern modes
   localparam logic MODE_FIVE  = 1'b0;
   localparam logic MODE_THREE = 1'b1;

   // register index (paddr[2])
   localparam logic REG_LOOKBACK = 1'b0;
   localparam logic REG_MODE     = 1'b1;

   localparam int PADDR_W = 3;

   // swing extrema, oldest first, valid entries packed at the low end
   typedef struct packed {
      logic [HIST_DEPTH-1:0][PRICE_W-1:0] price;
      logic [HIST_DEPTH-1:0][DAY_W-1:0]   day;
      logic [HIST_DEPTH-1:0]              trough;
      logic [HIST_DEPTH-1:0]              valid;
   } hist_type;

   // points of the last detected trend
   typedef struct packed {
      logic [HELD_POINTS-1:0][PRICE_W-1:0] price;
      logic [DAY_W-1:0]                    start_day;
      logic [DAY_W-1:0]                    end_day;
   } held_type;

   // configuration seen by the datapath
   typedef struct packed {
      logic [LOOKBACK_W-1:0] lookback_days;
      logic                  pattern_mode;
   } cfg_type;

endpackage

>>> rtl/swt_csr.sv
// APB-style configuration registers: lookback window and pattern mode.
// Depends on swt_pkg.
module swt_csr
   import swt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready,
   output cfg_type            cfg
);

   logic [LOOKBACK_W-1:0] lookback_ff;
   logic                  mode_ff;
   logic                  wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         lookback_ff <= LOOKBACK_RESET;
         mode_ff     <= MODE_FIVE;
      end else if (wr_en) begin
         case (paddr[2])
            REG_LOOKBACK: lookback_ff <= pwdata[LOOKBACK_W-1:0];
            REG_MODE:     mode_ff     <= pwdata[0];
            default:      ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_LOOKBACK: prdata = {{(32-LOOKBACK_W){1'b0}}, lookback_ff};
         REG_MODE:     prdata = {31'd0, mode_ff};
         default:      prdata = 32'd0;
      endcase
   end

   assign cfg.lookback_days = lookback_ff;
   assign cfg.pattern_mode  = mode_ff;

endmodule

>>> rtl/swt_history.sv
// Swing tracking state: previous close, day counter, direction and the
// extrema history with its window aging. Depends on swt_pkg.
module swt_history
   import swt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [PRICE_W-1:0]    close_price,
   input  logic [LOOKBACK_W-1:0] lookback_days,
   output hist_type              hist_next
);

   logic [PRICE_W-1:0] prev_ff, prev_in;
   logic [DAY_W-1:0]   day_ff, day_in;
   logic [1:0]         dir_ff, dir_in;
   hist_type           hist_ff;

   logic               rise, fall, rec, rec_trough;
   logic [CNT_W-1:0]   cnt, drop;
   logic               full, still;
   logic [DAY_W-1:0]   yday;
   hist_type           rec_h;
   logic [HIST_DEPTH-1:0] expired;

   always_comb begin
      rise       = close_price > prev_ff;
      fall       = close_price < prev_ff;
      rec        = 1'b0;
      rec_trough = 1'b0;
      dir_in     = dir_ff;
      if (day_ff != '0) begin
         case (dir_ff)
            DIR_UNKNOWN: begin
               if (rise) begin
                  rec = 1'b1; rec_trough = 1'b1; dir_in = DIR_UP;
               end else if (fall) begin
                  rec = 1'b1; dir_in = DIR_DOWN;
               end
            end
            DIR_UP: begin
               if (fall) begin
                  rec = 1'b1; dir_in = DIR_DOWN;
               end
            end
            DIR_DOWN: begin
               if (rise) begin
                  rec = 1'b1; rec_trough = 1'b1; dir_in = DIR_UP;
               end
            end
            default: ;
         endcase
      end
   end

   // record yesterday as an extremum; a full history pushes out the oldest
   always_comb begin
      cnt = '0;
      for (int j = 0; j < HIST_DEPTH; j++) begin
         cnt = cnt + CNT_W'(hist_ff.valid[j]);
      end
      full  = (cnt == CNT_W'(HIST_DEPTH));
      yday  = day_ff - DAY_W'(1);
      rec_h = hist_ff;
      if (rec) begin
         if (full) begin
            for (int j = 0; j < HIST_DEPTH - 1; j++) begin
               rec_h.price[j]  = hist_ff.price[j+1];
               rec_h.day[j]    = hist_ff.day[j+1];
               rec_h.trough[j] = hist_ff.trough[j+1];
            end
            rec_h.price[HIST_DEPTH-1]  = prev_ff;
            rec_h.day[HIST_DEPTH-1]    = yday;
            rec_h.trough[HIST_DEPTH-1] = rec_trough;
         end else begin
            for (int j = 0; j < HIST_DEPTH; j++) begin
               if (cnt == CNT_W'(j)) begin
                  rec_h.price[j]  = prev_ff;
                  rec_h.day[j]    = yday;
                  rec_h.trough[j] = rec_trough;
                  rec_h.valid[j]  = 1'b1;
               end
            end
         end
      end
   end

   // age out the leading extrema that fell outside the window
   always_comb begin
      for (int j = 0; j < HIST_DEPTH; j++) begin
         expired[j] = rec_h.valid[j] &&
                      ((day_ff - rec_h.day[j]) >= {{(DAY_W-LOOKBACK_W){1'b0}}, lookback_days});
      end
      drop  = '0;
      still = 1'b1;
      for (int j = 0; j < HIST_DEPTH; j++) begin
         still = still & expired[j];
         drop  = drop + CNT_W'(still);
      end
      hist_next       = rec_h;
      hist_next.valid = '0;
      for (int s = 0; s < HIST_DEPTH; s++) begin
         for (int j = 0; j <= s; j++) begin
            if (drop == CNT_W'(s - j)) begin
               hist_next.price[j]  = rec_h.price[s];
               hist_next.day[j]    = rec_h.day[s];
               hist_next.trough[j] = rec_h.trough[s];
               hist_next.valid[j]  = rec_h.valid[s];
            end
         end
      end
   end

   assign prev_in = close_price;
   assign day_in  = day_ff + DAY_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
         day_ff  <= '0;
         dir_ff  <= DIR_UNKNOWN;
         hist_ff <= '0;
      end else if (step) begin
         prev_ff <= prev_in;
         day_ff  <= day_in;
         dir_ff  <= dir_in;
         hist_ff <= hist_next;
      end
   end

`ifndef ASSERT_OFF
   a_valid_packed: assert property (@(posedge clock) disable iff (reset)
      (hist_ff.valid & (hist_ff.valid + HIST_DEPTH'(1))) == '0)
      else $error("extrema history is not packed oldest first");

   a_dir_code: assert property (@(posedge clock) disable iff (reset)
      dir_ff != DIR_BAD)
      else $error("swing direction holds the unused code");

   a_day_step: assert property (@(posedge clock) disable iff (reset)
      step |=> day_ff == $past(day_ff) + DAY_W'(1))
      else $error("day counter did not advance on a transfer");
`endif

endmodule

>>> rtl/swt_pattern.sv
// Trend pattern match over the newest extrema, five-point or three-point
// with breakout, and the next held trend points. Depends on swt_pkg.
module swt_pattern
   import swt_pkg::*;
(
   input  hist_type           hist,
   input  logic [PRICE_W-1:0] close_price,
   input  logic               pattern_mode,
   input  held_type           held,
   output logic [1:0]         trend_kind,
   output held_type           held_next
);

   logic [CNT_W-1:0]   cnt, base;
   logic [2:0][PRICE_W-1:0] p3;
   logic [2:0][DAY_W-1:0]   d3;
   logic [2:0]              t3;
   logic               up5, dn5, up3, dn3;
   held_type           found5, found3;

   always_comb begin
      cnt = '0;
      for (int j = 0; j < HIST_DEPTH; j++) begin
         cnt = cnt + CNT_W'(hist.valid[j]);
      end
      base = cnt - CNT_W'(3);
      p3 = '0;
      d3 = '0;
      t3 = '0;
      // pick the newest three extrema
      for (int s = 0; s < HIST_DEPTH; s++) begin
         for (int c = 0; c < 3; c++) begin
            if (CNT_W'(s) == base + CNT_W'(c)) begin
               p3[c] = hist.price[s];
               d3[c] = hist.day[s];
               t3[c] = hist.trough[s];
            end
         end
      end
   end

   always_comb begin
      up5 = (cnt >= CNT_W'(5)) &&
            hist.trough[0] && !hist.trough[1] && hist.trough[2] &&
            !hist.trough[3] && hist.trough[4] &&
            (hist.price[4] > hist.price[2]) && (hist.price[2] > hist.price[0]) &&
            (hist.price[3] > hist.price[1]);
      dn5 = (cnt >= CNT_W'(5)) &&
            !hist.trough[0] && hist.trough[1] && !hist.trough[2] &&
            hist.trough[3] && !hist.trough[4] &&
            (hist.price[4] < hist.price[2]) && (hist.price[2] < hist.price[0]) &&
            (hist.price[3] < hist.price[1]);
      up3 = (cnt >= CNT_W'(3)) && t3[0] && !t3[1] && t3[2] &&
            (p3[2] > p3[0]) && (close_price > p3[1]);
      dn3 = (cnt >= CNT_W'(3)) && !t3[0] && t3[1] && !t3[2] &&
            (p3[2] < p3[0]) && (close_price < p3[1]);

      for (int j = 0; j < HELD_POINTS; j++) begin
         found5.price[j] = hist.price[j];
      end
      found5.start_day = hist.day[0];
      found5.end_day   = hist.day[4];

      found3.price = '0;
      for (int c = 0; c < 3; c++) begin
         found3.price[c] = p3[c];
      end
      found3.start_day = d3[0];
      found3.end_day   = d3[2];

      trend_kind = TREND_NONE;
      held_next  = held;
      case (pattern_mode)
         MODE_FIVE: begin
            if (up5) begin
               trend_kind = TREND_UP;   held_next = found5;
            end else if (dn5) begin
               trend_kind = TREND_DOWN; held_next = found5;
            end
         end
         MODE_THREE: begin
            if (up3) begin
               trend_kind = TREND_UP;   held_next = found3;
            end else if (dn3) begin
               trend_kind = TREND_DOWN; held_next = found3;
            end
         end
         default: ;
      endcase
   end

endmodule

>>> rtl/swing_trend_detector.sv
// Swing trend detector top level: input register, history update and
// pattern match in one pass, result register that also holds the trend.
// Path: an accepted item waits in the input register and moves into the result
// register, raising rsp_valid, once that register is free or draining.
// Throughput: one item per cycle unless rsp_ready stalls; the step is set by the
// single-pass history shift, window aging and pattern compare between the two registers.
// Reset (synchronous): history and held points cleared, lookback 20, mode 0.
module swing_trend_detector
   import swt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [PRICE_W-1:0] req_close_price,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_trend_kind,
   output logic [PRICE_W-1:0] rsp_point_one_price,
   output logic [PRICE_W-1:0] rsp_point_two_price,
   output logic [PRICE_W-1:0] rsp_point_three_price,
   output logic [PRICE_W-1:0] rsp_point_four_price,
   output logic [PRICE_W-1:0] rsp_point_five_price,
   output logic [DAY_W-1:0]   rsp_start_day,
   output logic [DAY_W-1:0]   rsp_end_day,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   cfg_type            cfg;
   logic               in_valid_ff, in_valid_in;
   logic [PRICE_W-1:0] close_ff;
   logic               advance;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         kind_ff, kind_in;
   held_type           held_ff, held_in;
   hist_type           hist_next;

   swt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // move the held item on when the result register is free or draining
   assign advance     = in_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready   = ~in_valid_ff | advance;
   assign in_valid_in = (req_valid & req_ready) | (in_valid_ff & ~advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid & req_ready) begin
         close_ff <= req_close_price;
      end
   end

   swt_history u_history (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .close_price   (close_ff),
      .lookback_days (cfg.lookback_days),
      .hist_next     (hist_next)
   );

   swt_pattern u_pattern (
      .hist         (hist_next),
      .close_price  (close_ff),
      .pattern_mode (cfg.pattern_mode),
      .held         (held_ff),
      .trend_kind   (kind_in),
      .held_next    (held_in)
   );

   assign rsp_valid_in = advance | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         kind_ff      <= TREND_NONE;
         held_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            kind_ff <= kind_in;
            held_ff <= held_in;
         end
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_trend_kind        = kind_ff;
   assign rsp_point_one_price   = held_ff.price[0];
   assign rsp_point_two_price   = held_ff.price[1];
   assign rsp_point_three_price = held_ff.price[2];
   assign rsp_point_four_price  = held_ff.price[3];
   assign rsp_point_five_price  = held_ff.price[4];
   assign rsp_start_day         = held_ff.start_day;
   assign rsp_end_day           = held_ff.end_day;

`ifndef ASSERT_OFF
   a_kind_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> kind_ff != TREND_BAD)
      else $error("trend kind holds the unused code");

   a_held_on_none: assert property (@(posedge clock) disable iff (reset)
      advance && kind_in == TREND_NONE |=> $stable(held_ff))
      else $error("held trend points changed on a day without a trend");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(close_ff))
      else $error("input stage lost a stalled item");

   a_three_point_zero: assert property (@(posedge clock) disable iff (reset)
      advance && kind_in != TREND_NONE && cfg.pattern_mode == MODE_THREE
      |=> held_ff.price[3] == '0 && held_ff.price[4] == '0)
      else $error("three-point trend left stale fourth or fifth point");
`endif

endmodule
